>>> sv/smacs_pkg.sv
// Shared constants and result codes for the moving-average crossover signal unit.
package smacs_pkg;

  // Default sizes of the price ring and of one price sample.
  localparam int DEF_MAX_WINDOW = 256;
  localparam int DEF_PRICE_BITS = 32;

  // Headroom bits of the running sums above one price.
  localparam int SUM_HEADROOM = 12;

  // Configuration register indexes.
  localparam logic REG_SHORT_WINDOW = 1'b0;
  localparam logic REG_LONG_WINDOW  = 1'b1;

  // Width of the configuration write data.
  localparam int CFG_BITS = 9;

  // Reset values of the window registers.
  localparam logic [CFG_BITS-1:0] SHORT_WINDOW_RESET = 9'd5;
  localparam logic [CFG_BITS-1:0] LONG_WINDOW_RESET  = 9'd20;

  // Trading signal codes.
  localparam logic [1:0] SIG_HOLD = 2'd0;
  localparam logic [1:0] SIG_BUY  = 2'd1;
  localparam logic [1:0] SIG_SELL = 2'd2;

  // Result beat layout, lowest bit up: signal, trend_valid, short_above.
  localparam int RES_BITS = 8;

endpackage

>>> sv/smacs_ring.sv
// Price ring memory: one write port and two registered read ports, read-first.
module smacs_ring #(
  parameter int DEPTH = smacs_pkg::DEF_MAX_WINDOW,
  parameter int WIDTH = smacs_pkg::DEF_PRICE_BITS,
  parameter int ABITS = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ABITS-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [ABITS-1:0] raddr_a,
  input  logic [ABITS-1:0] raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the entry being written in the same cycle returns the old price.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

>>> sv/sma_crossover_signal_unit.sv
// Top level of the dual moving-average crossover signal unit.
//
//  Channel  Direction  Beat content (lowest bit up)
//  -------  ---------  ---------------------------------------------------
//  s_*      in         tdata: price[31:0]; tuser: new_series
//  m_*      out        tdata: signal[1:0], trend_valid, short_above, zeros
//  cfg_*    in         index 0 short window length, index 1 long window length (9 bits)
//
// One price is accepted every cycle while the skid entry is empty; the ring memory does
// two retire reads and one write per beat, and the running sums close their loop in a
// single stage. A result passes stage 1, the sums, stage 2 and the output register.
// Reset clears the counters, sums and trend flag at once; the ring needs no pass.
// A stalled result waits in the output register with a one-beat skid behind it;
// s_tready drops only while that skid entry is occupied.
module sma_crossover_signal_unit #(
  parameter int MAX_WINDOW = smacs_pkg::DEF_MAX_WINDOW,
  parameter int PRICE_BITS = smacs_pkg::DEF_PRICE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input beat: tdata = price[31:0]; tuser = new_series.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,
  input  logic                          s_tuser,
  // Result beat: tdata = signal[1:0], trend_valid, short_above, zero fill.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [smacs_pkg::RES_BITS-1:0] m_tdata,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [smacs_pkg::CFG_BITS-1:0] cfg_wdata
);

  import smacs_pkg::*;

  localparam int PTR_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int AW       = PTR_BITS + 1;
  localparam int CNT_BITS = $clog2(MAX_WINDOW + 2);
  localparam int CW       = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;
  localparam int SUM_BITS = PRICE_BITS + SUM_HEADROOM;
  localparam int PROD_BITS = SUM_BITS + CNT_BITS;
  localparam int PX       = (PRICE_BITS > 32) ? PRICE_BITS : 32;

  localparam logic [CNT_BITS-1:0] CNT_SAT  = CNT_BITS'(MAX_WINDOW + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(MAX_WINDOW - 1);
  localparam logic [AW-1:0]       DEPTH_A  = AW'(MAX_WINDOW);

  // Window register saturated to the range one to MAX_WINDOW.
  function automatic logic [CNT_BITS-1:0] clamp_win(input logic [CFG_BITS-1:0] w);
    logic [CW-1:0] wx;
    logic [CW-1:0] r;
    wx = CW'(w);
    if (wx == '0) begin
      r = CW'(1);
    end else if (wx > CW'(MAX_WINDOW)) begin
      r = CW'(MAX_WINDOW);
    end else begin
      r = wx;
    end
    return CNT_BITS'(r);
  endfunction

  // Retire address: pointer minus window, modulo the ring depth.
  function automatic logic [PTR_BITS-1:0] back_addr(input logic [PTR_BITS-1:0] p,
                                                    input logic [CNT_BITS-1:0] w);
    logic [AW-1:0] a;
    a = {1'b0, p} + DEPTH_A - AW'(w);
    if (a >= DEPTH_A) begin
      a = a - DEPTH_A;
    end
    return a[PTR_BITS-1:0];
  endfunction

  // Configuration registers.
  logic [CFG_BITS-1:0] win_short;
  logic [CFG_BITS-1:0] win_long;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_short <= SHORT_WINDOW_RESET;
      win_long  <= LONG_WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHORT_WINDOW: win_short <= cfg_wdata;
        REG_LONG_WINDOW:  win_long  <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  logic [CNT_BITS-1:0] sw;
  logic [CNT_BITS-1:0] lw;
  assign sw = clamp_win(win_short);
  assign lw = clamp_win(win_long);

  // Pipeline enable: everything moves unless the output skid is occupied.
  logic skid_v;
  logic en;
  logic accept;
  assign en       = !skid_v;
  assign s_tready = en;
  assign accept   = s_tvalid && s_tready;

  // Stage 0: sample index, retire decisions and ring addresses.
  logic [PX-1:0]         price_ext;
  logic [PRICE_BITS-1:0] price_in;
  logic [PTR_BITS-1:0]   write_pointer;
  logic [PTR_BITS-1:0]   write_pointer_next;
  logic [CNT_BITS-1:0]   sample_count;
  logic [CNT_BITS-1:0]   idx;
  logic [CNT_BITS-1:0]   sample_count_next;

  assign price_ext = PX'(s_tdata);
  assign price_in  = price_ext[PRICE_BITS-1:0];
  assign idx       = s_tuser ? '0 : sample_count;

  always_comb begin
    write_pointer_next = (write_pointer == PTR_LAST) ? '0
                                                     : write_pointer + PTR_BITS'(1);
    sample_count_next  = (idx < CNT_SAT) ? idx + CNT_BITS'(1) : idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      sample_count  <= '0;
    end else if (accept) begin
      write_pointer <= write_pointer_next;
      sample_count  <= sample_count_next;
    end
  end

  logic [PRICE_BITS-1:0] ret_s_price;
  logic [PRICE_BITS-1:0] ret_l_price;

  smacs_ring #(
    .DEPTH (MAX_WINDOW),
    .WIDTH (PRICE_BITS),
    .ABITS (PTR_BITS)
  ) u_ring (
    .clk     (clk),
    .we      (accept),
    .waddr   (write_pointer),
    .wdata   (price_in),
    .re      (accept),
    .raddr_a (back_addr(write_pointer, sw)),
    .raddr_b (back_addr(write_pointer, lw)),
    .rdata_a (ret_s_price),
    .rdata_b (ret_l_price)
  );

  // Stage 1 registers: the beat, its flags; ring data lands alongside.
  logic                  v1;
  logic [PRICE_BITS-1:0] price1;
  logic                  ns1;
  logic                  ret_s1;
  logic                  ret_l1;
  logic                  vidx1;
  logic                  late1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      price1 <= price_in;
      ns1    <= s_tuser;
      ret_s1 <= idx >= sw;
      ret_l1 <= idx >= lw;
      vidx1  <= (idx >= lw) && (idx >= sw - CNT_BITS'(1));
      late1  <= idx > lw;
    end
  end

  // Stage 1: sums drop retired prices and add the new one, or restart on a new series.
  logic [SUM_BITS-1:0] short_sum;
  logic [SUM_BITS-1:0] long_sum;
  logic [SUM_BITS-1:0] short_sum_next;
  logic [SUM_BITS-1:0] long_sum_next;

  always_comb begin
    short_sum_next = (ns1 ? '0 : short_sum)
                   - (ret_s1 ? SUM_BITS'(ret_s_price) : '0)
                   + SUM_BITS'(price1);
    long_sum_next  = (ns1 ? '0 : long_sum)
                   - (ret_l1 ? SUM_BITS'(ret_l_price) : '0)
                   + SUM_BITS'(price1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_sum <= '0;
      long_sum  <= '0;
    end else if (en && v1) begin
      short_sum <= short_sum_next;
      long_sum  <= long_sum_next;
    end
  end

  logic v2;
  logic ns2;
  logic vidx2;
  logic late2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ns2   <= ns1;
      vidx2 <= vidx1;
      late2 <= late1;
    end
  end

  // Stage 2: cross products of the sums with the opposite window.
  logic                 v3;
  logic                 ns3;
  logic                 valid3;
  logic                 late3;
  logic [PROD_BITS-1:0] prod_s;
  logic [PROD_BITS-1:0] prod_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ns3    <= ns2;
      late3  <= late2;
      valid3 <= vidx2 && (short_sum != '0) && (long_sum != '0);
      prod_s <= PROD_BITS'(short_sum) * PROD_BITS'(lw);
      prod_l <= PROD_BITS'(long_sum) * PROD_BITS'(sw);
    end
  end

  // Stage 3: compare, crossover detection and trend flag update.
  logic                push;
  logic                above;
  logic                trend_up;
  logic                prev_base;
  logic                trend_up_next;
  logic [1:0]          sig;
  logic [RES_BITS-1:0] res;

  assign push = en && v3;

  always_comb begin
    above         = prod_s > prod_l;
    prev_base     = ns3 ? 1'b0 : trend_up;
    trend_up_next = valid3 ? above : prev_base;
    sig           = SIG_HOLD;
    if (valid3 && late3) begin
      if (above && !prev_base) begin
        sig = SIG_BUY;
      end else if (!above && prev_base) begin
        sig = SIG_SELL;
      end
    end
    res = {{(RES_BITS - 4){1'b0}}, trend_up_next, valid3, sig};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trend_up <= 1'b0;
    end else if (push) begin
      trend_up <= trend_up_next;
    end
  end

  // Output register with a one-beat skid entry behind it.
  logic                out_v;
  logic [RES_BITS-1:0] out_data;
  logic [RES_BITS-1:0] skid_data;
  logic                pop;

  assign pop = out_v && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (pop) begin
        skid_v <= 1'b0;
      end
    end else if (push) begin
      if (out_v && !pop) begin
        skid_v <= 1'b1;
      end else begin
        out_v <= 1'b1;
      end
    end else if (pop) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_v && !pop) begin
        skid_data <= res;
      end else begin
        out_data <= res;
      end
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = out_data;

endmodule

>>> sv/smacs_checker.sv
// Port-level checks for the crossover signal unit, bound to its top level.
module smacs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [smacs_pkg::RES_BITS-1:0] m_tdata
);

  import smacs_pkg::*;

  // A stalled result beat holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  // With no result waiting the skid is empty, so input is taken.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // A crossover is reported only on a valid trend, agreeing with the stored relation.
  a_buy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == SIG_BUY |-> m_tdata[2] && m_tdata[3])
    else $error("buy without valid rising relation");

  a_sell: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != SIG_HOLD && m_tdata[1:0] != SIG_BUY
      |-> m_tdata[1:0] == SIG_SELL && m_tdata[2] && !m_tdata[3])
    else $error("bad signal code or sell without valid falling relation");

endmodule

bind sma_crossover_signal_unit smacs_checker u_smacs_checker (.*);

>>> test/tb.sv
// Self-checking testbench for the dual moving-average crossover signal unit.
module tb;
  import smacs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int RING_DEPTH = DEF_MAX_WINDOW;
  localparam int SUM_W = DEF_PRICE_BITS + SUM_HEADROOM;

  typedef struct packed {
    logic        new_series;
    logic [31:0] price;
  } price_beat_t;

  // Result fields as they sit in the low bits of m_tdata.
  typedef struct packed {
    logic       short_above;
    logic       trend_valid;
    logic [1:0] signal;
  } trade_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [31:0]         s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [RES_BITS-1:0] m_tdata;
  logic                cfg_we = 1'b0;
  logic                cfg_index = REG_SHORT_WINDOW;
  logic [CFG_BITS-1:0] cfg_wdata = '0;

  // Predicted state of the unit.
  logic [31:0]         price_hist [RING_DEPTH];
  logic [7:0]          wr_ptr = '0;
  logic [SUM_W-1:0]    short_total = '0;
  logic [SUM_W-1:0]    long_total = '0;
  logic [8:0]          samp_idx = '0;
  logic                was_above = 1'b0;
  logic [CFG_BITS-1:0] short_len = SHORT_WINDOW_RESET;
  logic [CFG_BITS-1:0] long_len = LONG_WINDOW_RESET;

  trade_result_t       expected_q[$];
  price_beat_t         pend_q[$];

  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  logic                pressure_on = 1'b0;
  int                  hold_left = 0;
  logic                hold_done = 1'b0;
  int                  mismatches = 0;
  int                  cycle_count = 0;

  // Price generator state: a random walk with a drifting trend.
  longint              walk = 0;
  int                  drift = 0;
  int                  series_left = 0;
  int                  zero_lead = 0;

  sma_crossover_signal_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // price[31:0]
    .s_tuser  (s_tuser),   // new_series
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // signal[1:0], trend_valid, short_above, zero fill
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // A window register of zero acts as one; anything above the ring depth saturates.
  function automatic logic [8:0] eff_window(input logic [CFG_BITS-1:0] w);
    if (w == 0) return 9'd1;
    if (w > RING_DEPTH) return 9'(RING_DEPTH);
    return w;
  endfunction

  // Advance the predicted state by one price and queue the expected result.
  function automatic void crossover_step(input logic [31:0] price, input logic restart);
    logic [8:0]    sw;
    logic [8:0]    lw;
    logic [8:0]    idx;
    logic [7:0]    rd_ptr;
    logic          valid;
    logic          above;
    logic [63:0]   short_cross;
    logic [63:0]   long_cross;
    trade_result_t res;
    sw = eff_window(short_len);
    lw = eff_window(long_len);
    if (restart) begin
      samp_idx = '0;
      short_total = '0;
      long_total = '0;
      was_above = 1'b0;
    end
    idx = samp_idx;
    // Retire the prices that fall out of each window before the new one lands.
    if (idx >= sw) begin
      rd_ptr = wr_ptr - sw[7:0];
      short_total = short_total - SUM_W'(price_hist[rd_ptr]);
    end
    if (idx >= lw) begin
      rd_ptr = wr_ptr - lw[7:0];
      long_total = long_total - SUM_W'(price_hist[rd_ptr]);
    end
    short_total = short_total + SUM_W'(price);
    long_total = long_total + SUM_W'(price);
    price_hist[wr_ptr] = price;
    wr_ptr = wr_ptr + 8'd1;
    if (samp_idx < RING_DEPTH + 1) samp_idx = samp_idx + 9'd1;

    valid = (idx >= lw) && (idx + 1 >= sw) && (short_total != 0) && (long_total != 0);
    res.signal = SIG_HOLD;
    if (valid) begin
      // Cross-multiplied compare of the two averages.
      short_cross = 64'(short_total) * 64'(lw);
      long_cross = 64'(long_total) * 64'(sw);
      above = short_cross > long_cross;
      // A valid sample at index lw only records the relation.
      if (idx > lw) begin
        if (above && !was_above) res.signal = SIG_BUY;
        else if (!above && was_above) res.signal = SIG_SELL;
      end
      was_above = above;
    end
    res.trend_valid = valid;
    res.short_above = was_above;
    expected_q = {expected_q, res};
  endfunction

  function automatic logic [31:0] gen_price();
    int pick;
    pick = $urandom_range(99);
    if (pick < 3) return '0;
    if (pick < 6) return '1;
    if (pick < 14) return $urandom;
    if ($urandom_range(15) == 0) drift = int'($urandom_range(4000)) - 2000;
    walk = walk + drift + (int'($urandom_range(600)) - 300);
    if (walk < 0) walk = 0;
    if (walk > 64'sd4294967295) walk = 64'sd4294967295;
    return walk[31:0];
  endfunction

  // Price beat driver: holds a beat until it is taken, then offers the next one.
  always @(posedge clk) begin : price_drive
    price_beat_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) crossover_step(s_tdata, s_tuser);
      if (!(s_tvalid && !s_tready)) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pend_q.pop_front();
          s_tdata <= nxt.price;
          s_tuser <= nxt.new_series;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result ready: random stalls, plus one long hold-off to fill the unit.
  always @(posedge clk) begin : result_ready
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (pressure_on && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare each result beat with the oldest expected result.
  always @(posedge clk) begin : result_check
    trade_result_t got;
    trade_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = trade_result_t'(m_tdata[3:0]);
      if (expected_q.size() == 0) begin
        $error("result beat %h arrived with nothing expected", m_tdata);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (got.signal !== want.signal) begin
          $error("signal: expected %0d, got %0d", want.signal, got.signal);
          mismatches++;
        end
        if (got.trend_valid !== want.trend_valid) begin
          $error("trend_valid: expected %0d, got %0d", want.trend_valid, got.trend_valid);
          mismatches++;
        end
        if (got.short_above !== want.short_above) begin
          $error("short_above: expected %0d, got %0d", want.short_above, got.short_above);
          mismatches++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic set_windows(input logic [CFG_BITS-1:0] sw, input logic [CFG_BITS-1:0] lw);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_SHORT_WINDOW;
    cfg_wdata <= sw;
    @(posedge clk);
    cfg_index <= REG_LONG_WINDOW;
    cfg_wdata <= lw;
    @(posedge clk);
    cfg_we <= 1'b0;
    short_len = sw;
    long_len = lw;
  endtask

  // Wait until every beat is taken and every result is back, then let the pipe empty.
  task automatic wait_drained();
    do @(negedge clk);
    while (pend_q.size() != 0 || s_tvalid || expected_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_beat(input logic [31:0] price, input logic restart);
    price_beat_t b;
    b.price = price;
    b.new_series = restart;
    pend_q = {pend_q, b};
  endtask

  // One random phase: mostly whole series long enough to fill both windows,
  // with zero-price openings and stray restarts mixed in.
  task automatic run_phase(input int sw, input int lw, input int send_idle,
                           input int recv_stall, input int beats, input logic hold);
    price_beat_t b;
    int          span;
    set_windows(sw[CFG_BITS-1:0], lw[CFG_BITS-1:0]);
    @(negedge clk);
    send_idle_pct = send_idle;
    recv_stall_pct = recv_stall;
    pressure_on = hold;
    span = int'(eff_window(sw[CFG_BITS-1:0]));
    if (int'(eff_window(lw[CFG_BITS-1:0])) > span) span = int'(eff_window(lw[CFG_BITS-1:0]));
    for (int k = 0; k < beats; k++) begin
      b.new_series = 1'b0;
      if (series_left == 0) begin
        b.new_series = 1'b1;
        series_left = $urandom_range(2 * span + 40, span + 4);
        walk = $urandom_range(1) ? longint'($urandom) : longint'($urandom_range(100000));
        drift = int'($urandom_range(4000)) - 2000;
        zero_lead = ($urandom_range(7) == 0) ? $urandom_range(12, 1) : 0;
      end else if ($urandom_range(49) == 0) begin
        b.new_series = 1'b1;
      end
      series_left--;
      if (zero_lead > 0) begin
        b.price = '0;
        zero_lead--;
      end else begin
        b.price = gen_price();
      end
      pend_q = {pend_q, b};
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: tiny windows so zero sums, the recording sample, buy, sell,
    // hold and extreme prices all show up within a few beats.
    set_windows(9'd2, 9'd3);
    @(negedge clk);
    add_beat(32'd0, 1'b1);
    add_beat(32'd0, 1'b0);
    add_beat(32'd0, 1'b0);
    add_beat(32'd0, 1'b0);
    add_beat(32'd100, 1'b1);
    add_beat(32'd100, 1'b0);
    add_beat(32'd100, 1'b0);
    add_beat(32'd200, 1'b0);
    add_beat(32'd50, 1'b0);
    add_beat(32'd10, 1'b0);
    add_beat(32'd10, 1'b0);
    add_beat(32'd500, 1'b0);
    add_beat(32'hFFFF_FFFF, 1'b0);
    add_beat(32'hFFFF_FFFF, 1'b0);
    add_beat(32'hFFFF_FFFF, 1'b0);
    add_beat(32'd0, 1'b0);
    add_beat(32'hFFFF_FFFF, 1'b0);
    add_beat(32'hAAAA_AAAA, 1'b1);
    add_beat(32'h5555_5555, 1'b0);
    add_beat(32'h0000_0001, 1'b0);
    add_beat(32'h8000_0000, 1'b0);
    add_beat(32'hFFFF_FFFF, 1'b0);
    wait_drained();

    // Random phases across window settings and flow-control patterns.
    run_phase(3, 8, 0, 0, 150, 1'b0);
    run_phase(5, 20, 46, 0, 150, 1'b0);
    run_phase(1, 4, 0, 46, 150, 1'b0);
    run_phase(10, 0, 17, 17, 150, 1'b0);
    run_phase(40, 256, 0, 0, 280, 1'b0);
    // Windows change while a long series is still running.
    run_phase(511, 300, 0, 0, 70, 1'b1);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/smacs_pkg.sv
sv/smacs_ring.sv
sv/sma_crossover_signal_unit.sv
sv/smacs_checker.sv
test/tb.sv
